FILE: design/ddo_pkg.sv
// shared constants, widths and the arctangent table for the odometry block
// no dependencies; imported by ddo_cordic, ddo_div and diff_drive_odometry

package ddo_pkg;

   localparam int DATA_W     = 32;
   localparam int ANGLE_W    = 32;
   localparam int CMD_W      = 2;
   localparam int CFG_W      = 24;
   localparam int CSR_ADDR_W = 2;

   localparam int REQ_DATA_W = 7 * DATA_W;
   localparam int RSP_DATA_W = 3 * DATA_W;

   localparam logic [CMD_W-1:0] CMD_BODY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WHEEL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AXLE_LENGTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP    = 2'd2;

   localparam logic [CFG_W-1:0] RADIUS_RST = 24'd6554;
   localparam logic [CFG_W-1:0] AXLE_RST   = 24'd32768;
   localparam logic [CFG_W-1:0] TSTEP_RST  = 24'd167772;

   // fraction bits of velocities and positions
   localparam int FRAC_BITS  = 16;
   localparam int TURN_SHIFT = FRAC_BITS + 26 - 32;

   localparam int V_SHIFT    = 17;
   localparam int TRIG_SHIFT = 30;
   localparam int TS_SHIFT   = 24;

   // multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // divider: magnitude of radius times wheel-rate difference
   localparam int DIV_W = 56;

   localparam int CORDIC_W          = 34;
   localparam int TRIG_W            = 33;
   localparam int ATAN_IDX_W        = 5;
   localparam int CORDIC_STEPS_DFLT = 24;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30     = 34'sd652032874;
   localparam logic [DATA_W-1:0]          TURN_PER_RAD = 32'd2734261102;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              hit;
   } clip_type;

   // atan(2^-k) as a fraction of a full turn, 2^32 per turn
   function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] k);
      logic [ANGLE_W-1:0] a;
      case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

FILE: design/ddo_cordic.sv
// iterative rotation-mode cordic: one micro-rotation per cycle, cos and sin in q2.30
// depends on ddo_pkg

module ddo_cordic #(
   parameter int STEPS = ddo_pkg::CORDIC_STEPS_DFLT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ddo_pkg::ANGLE_W-1:0]         angle,
   output logic                                done,
   output logic signed [ddo_pkg::TRIG_W-1:0]   cos_q,
   output logic signed [ddo_pkg::TRIG_W-1:0]   sin_q
);
   import ddo_pkg::*;

   localparam int CntW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CntW-1:0] LastCnt = CntW'(STEPS - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       flip_ff, flip_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORDIC_W-1:0] x_sh, y_sh, atan_ext;
   logic [ANGLE_W-1:0]         ang_fold;
   logic                       start_flip;

   always_comb begin
      // second and third quadrant are folded by a half turn and negated at the end
      start_flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
      ang_fold   = angle ^ {start_flip, {(ANGLE_W-1){1'b0}}};
      x_sh       = x_ff >>> cnt_ff;
      y_sh       = y_ff >>> cnt_ff;
      atan_ext   = $signed({{(CORDIC_W-ANGLE_W){1'b0}}, atan_turn(ATAN_IDX_W'(cnt_ff))});

      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         flip_in = start_flip;
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = CORDIC_W'($signed(ang_fold));
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_ext;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign cos_q = TRIG_W'(flip_ff ? -x_ff : x_ff);
   assign sin_q = TRIG_W'(flip_ff ? -y_ff : y_ff);

endmodule

FILE: design/ddo_div.sv
// restoring divider for the angular velocity from wheel rates, one quotient bit per cycle
// depends on ddo_pkg

module ddo_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ddo_pkg::DIV_W-1:0]    dividend,
   input  logic [ddo_pkg::CFG_W-1:0]    divisor,
   output logic                         done,
   output logic [ddo_pkg::DIV_W-1:0]    quotient
);
   import ddo_pkg::*;

   localparam int CntW = $clog2(DIV_W);
   localparam logic [CntW-1:0] LastCnt = CntW'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [CFG_W-1:0] rem_ff, rem_in;
   logic [CFG_W:0]   trial, trial_sub;
   logic             fits;

   always_comb begin
      // dividend bits leave at the top of q_ff while quotient bits enter at the bottom
      trial     = {rem_ff, q_ff[DIV_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = trial >= {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: design/diff_drive_odometry.sv
// differential-drive odometry top level: pose registers, sequencer and shared multiplier
// depends on ddo_pkg, ddo_cordic and ddo_div
//
// usage:
//   req channel: one beat per command. tuser carries cmd; tdata carries the velocities,
//   wheel rates and load values. a body velocity step (cmd 0) or wheel rate step (cmd 1)
//   advances the pose by one euler step using the heading from before the beat; a load
//   (cmd 2) writes the pose; cmd 3 leaves the pose as it is.
//   rsp channel: exactly one beat per request with the pose after the update and the
//   saturation flag in tuser.
//   csr channel: always ready; writes wheel radius, axle length and time step. write only
//   while no request is in flight.
// timing: load and cmd 3 give their beat the cycle after acceptance. a body step runs the
//   cordic rotation and then the euler step; a wheel step first derives v and w, with a
//   56-bit bit-serial divide for w. the cordic and the divider iterate one step per cycle
//   and every product goes through one 33x33 multiplier. one request is in work at a time;
//   req_tready is low until the sequencer is idle again.
// reset: pose clears to zero, the registers take their default values, no beat pending.
// a stalled rsp beat holds in the output register; a new request is still taken when
//   the pending beat leaves in the same cycle.

module diff_drive_odometry #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DFLT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lin_vel, ang_vel, right_rate, left_rate, load_x, load_y, load_heading
   input  logic [ddo_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd
   input  logic [ddo_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pos_x, pos_y, heading
   output logic [ddo_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // saturated
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddo_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ddo_pkg::CFG_W-1:0]           csr_wdata
);
   import ddo_pkg::*;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_VMUL  = 5'd1;
   localparam logic [4:0] ST_WMUL  = 5'd2;
   localparam logic [4:0] ST_DIVGO = 5'd3;
   localparam logic [4:0] ST_DIVW  = 5'd4;
   localparam logic [4:0] ST_CGO   = 5'd5;
   localparam logic [4:0] ST_CWAIT = 5'd6;
   localparam logic [4:0] ST_MX    = 5'd7;
   localparam logic [4:0] ST_MY    = 5'd8;
   localparam logic [4:0] ST_DX    = 5'd9;
   localparam logic [4:0] ST_DY    = 5'd10;
   localparam logic [4:0] ST_DW    = 5'd11;
   localparam logic [4:0] ST_MAG   = 5'd12;
   localparam logic [4:0] ST_LO    = 5'd13;
   localparam logic [4:0] ST_HI    = 5'd14;
   localparam logic [4:0] ST_TURN  = 5'd15;
   localparam logic [4:0] ST_DONE  = 5'd16;

   localparam logic signed [PROD_W-1:0] HalfV    = PROD_W'(65536);
   localparam logic signed [PROD_W-1:0] HalfTrig = PROD_W'(536870912);
   localparam logic signed [PROD_W-1:0] HalfTs   = PROD_W'(8388608);
   localparam logic signed [PROD_W-1:0] MaxS32   = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] MinS32   = PROD_W'(-64'sd2147483648);
   localparam logic [63:0]              HalfTurn = 64'd1 << (TURN_SHIFT - 1);

   function automatic clip_type clip32(input logic signed [PROD_W-1:0] v);
      clip_type r;
      if (v > MaxS32) begin
         r.value = 32'h7FFFFFFF;
         r.hit   = 1'b1;
      end else if (v < MinS32) begin
         r.value = 32'h80000000;
         r.hit   = 1'b1;
      end else begin
         r.value = v[DATA_W-1:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   logic [4:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]         rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_h_ff, rsp_h_in;
   logic                      rsp_sat_ff, rsp_sat_in;
   logic signed [DATA_W-1:0]  pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [ANGLE_W-1:0]        pose_h_ff, pose_h_in;
   logic [CFG_W-1:0]          radius_ff, radius_in, axle_ff, axle_in, tstep_ff, tstep_in;
   logic signed [DATA_W-1:0]  v_ff, v_in, w_ff, w_in;
   logic signed [MUL_W-1:0]   sum_ff, sum_in, diff_ff, diff_in;
   logic signed [MUL_W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [DIV_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [DATA_W-1:0]         lo_ff, lo_in;
   logic                      sat_ff, sat_in;
   logic signed [PROD_W-1:0]  p_ff, p_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  p_abs, rnd_v, rnd_trig, rnd_ts, quo_ext;
   logic [63:0]               turn_acc;
   logic [DATA_W-1:0]         turn_d;
   logic [CFG_W-1:0]          divisor;
   logic [DIV_W-1:0]          div_q;
   logic                      div_go, div_done, cordic_go, cordic_done, rsp_free;
   logic signed [TRIG_W-1:0]  cos_q, sin_q;
   clip_type                  clip_r;

   logic [CMD_W-1:0]          f_cmd;
   logic signed [DATA_W-1:0]  f_lin, f_ang, f_right, f_left, f_load_x, f_load_y;
   logic [ANGLE_W-1:0]        f_load_h;

   assign f_cmd    = req_tuser;
   assign f_lin    = req_tdata[0*DATA_W +: DATA_W];
   assign f_ang    = req_tdata[1*DATA_W +: DATA_W];
   assign f_right  = req_tdata[2*DATA_W +: DATA_W];
   assign f_left   = req_tdata[3*DATA_W +: DATA_W];
   assign f_load_x = req_tdata[4*DATA_W +: DATA_W];
   assign f_load_y = req_tdata[5*DATA_W +: DATA_W];
   assign f_load_h = req_tdata[6*DATA_W +: DATA_W];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign csr_ready  = 1'b1;
   // a zero axle length divides as the smallest step
   assign divisor    = (axle_ff == '0) ? CFG_W'(1) : axle_ff;

   ddo_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_go),
      .angle (pose_h_ff),
      .done  (cordic_done),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (p_abs[DIV_W-1:0]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      p_abs    = p_ff[PROD_W-1] ? -p_ff : p_ff;
      rnd_v    = (p_ff + HalfV) >>> V_SHIFT;
      rnd_trig = (p_ff + HalfTrig) >>> TRIG_SHIFT;
      rnd_ts   = (p_ff + HalfTs) >>> TS_SHIFT;
      quo_ext  = $signed({{(PROD_W-DIV_W){1'b0}}, div_q});
      turn_acc = p_ff[63:0] + {32'b0, lo_ff} + HalfTurn;
      turn_d   = turn_acc[TURN_SHIFT +: DATA_W];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_sat_in   = rsp_sat_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_h_in    = pose_h_ff;
      radius_in    = radius_ff;
      axle_in      = axle_ff;
      tstep_in     = tstep_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      lo_in        = lo_ff;
      sat_in       = sat_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_go       = 1'b0;
      cordic_go    = 1'b0;
      clip_r       = '0;

      if (csr_valid) begin
         case (csr_addr)
            CSR_WHEEL_RADIUS: radius_in = csr_wdata;
            CSR_AXLE_LENGTH:  axle_in   = csr_wdata;
            CSR_TIME_STEP:    tstep_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               sat_in = 1'b0;
               case (f_cmd)
                  CMD_BODY: begin
                     v_in     = f_lin;
                     w_in     = f_ang;
                     state_in = ST_CGO;
                  end
                  CMD_WHEEL: begin
                     sum_in   = MUL_W'(f_right) + MUL_W'(f_left);
                     diff_in  = MUL_W'(f_right) - MUL_W'(f_left);
                     state_in = ST_VMUL;
                  end
                  CMD_LOAD: begin
                     pose_x_in    = f_load_x;
                     pose_y_in    = f_load_y;
                     pose_h_in    = f_load_h;
                     rsp_x_in     = f_load_x;
                     rsp_y_in     = f_load_y;
                     rsp_h_in     = f_load_h;
                     rsp_sat_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     // unused command: echo the pose
                     rsp_x_in     = pose_x_ff;
                     rsp_y_in     = pose_y_ff;
                     rsp_h_in     = pose_h_ff;
                     rsp_sat_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_VMUL: begin
            mul_a    = $signed({{(MUL_W-CFG_W){1'b0}}, radius_ff});
            mul_b    = sum_ff;
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            clip_r   = clip32(rnd_v);
            v_in     = clip_r.value;
            mul_a    = $signed({{(MUL_W-CFG_W){1'b0}}, radius_ff});
            mul_b    = diff_ff;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            div_go   = 1'b1;
            neg_in   = p_ff[PROD_W-1];
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               // truncating divide: magnitude quotient with the sign put back
               clip_r   = clip32(neg_ff ? -quo_ext : quo_ext);
               w_in     = clip_r.value;
               state_in = ST_CGO;
            end
         end
         ST_CGO: begin
            cordic_go = 1'b1;
            state_in  = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (cordic_done) begin
               state_in = ST_MX;
            end
         end
         ST_MX: begin
            mul_a    = MUL_W'(v_ff);
            mul_b    = cos_q;
            state_in = ST_MY;
         end
         ST_MY: begin
            ax_in    = MUL_W'(rnd_trig);
            mul_a    = MUL_W'(v_ff);
            mul_b    = sin_q;
            state_in = ST_DX;
         end
         ST_DX: begin
            ay_in    = MUL_W'(rnd_trig);
            mul_a    = ax_ff;
            mul_b    = $signed({{(MUL_W-CFG_W){1'b0}}, tstep_ff});
            state_in = ST_DY;
         end
         ST_DY: begin
            clip_r    = clip32(rnd_ts + PROD_W'(pose_x_ff));
            pose_x_in = clip_r.value;
            sat_in    = sat_ff | clip_r.hit;
            mul_a     = ay_ff;
            mul_b     = $signed({{(MUL_W-CFG_W){1'b0}}, tstep_ff});
            state_in  = ST_DW;
         end
         ST_DW: begin
            clip_r    = clip32(rnd_ts + PROD_W'(pose_y_ff));
            pose_y_in = clip_r.value;
            sat_in    = sat_ff | clip_r.hit;
            mul_a     = MUL_W'(w_ff);
            mul_b     = $signed({{(MUL_W-CFG_W){1'b0}}, tstep_ff});
            state_in  = ST_MAG;
         end
         ST_MAG: begin
            mag_in   = p_abs[DIV_W-1:0];
            neg_in   = p_ff[PROD_W-1];
            state_in = ST_LO;
         end
         ST_LO: begin
            // radians to turns in two 32-bit halves
            mul_a    = $signed({1'b0, mag_ff[DATA_W-1:0]});
            mul_b    = $signed({1'b0, TURN_PER_RAD});
            state_in = ST_HI;
         end
         ST_HI: begin
            lo_in    = p_ff[63:32];
            mul_a    = $signed({{(MUL_W-(DIV_W-DATA_W)){1'b0}}, mag_ff[DIV_W-1:DATA_W]});
            mul_b    = $signed({1'b0, TURN_PER_RAD});
            state_in = ST_TURN;
         end
         ST_TURN: begin
            pose_h_in = pose_h_ff + (neg_ff ? (32'd0 - turn_d) : turn_d);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_x_in     = pose_x_ff;
               rsp_y_in     = pose_y_ff;
               rsp_h_in     = pose_h_ff;
               rsp_sat_in   = sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      p_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         radius_ff    <= RADIUS_RST;
         axle_ff      <= AXLE_RST;
         tstep_ff     <= TSTEP_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
         radius_ff    <= radius_in;
         axle_ff      <= axle_in;
         tstep_ff     <= tstep_in;
      end
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_sat_ff <= rsp_sat_in;
      v_ff       <= v_in;
      w_ff       <= w_in;
      sum_ff     <= sum_in;
      diff_ff    <= diff_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      lo_ff      <= lo_in;
      sat_ff     <= sat_in;
      p_ff       <= p_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_h_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

FILE: verif/tb_diff_drive_odometry.sv
// testbench for diff_drive_odometry: directed and random command streams with an
// in-bench pose predictor (cordic, euler step, saturation); depends on ddo_pkg and the dut
`timescale 1ns / 100ps

module tb_diff_drive_odometry;

   localparam int CORDIC_ITERS = 24;
   localparam logic [ddo_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [ddo_pkg::CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [23:0] DEFAULT_RADIUS = 24'd6554;
   localparam logic [23:0] DEFAULT_AXLE   = 24'd32768;
   localparam logic [23:0] DEFAULT_TSTEP  = 24'd167772;
   localparam logic [23:0] CFG_MAX        = 24'hFFFFFF;

   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint unsigned RAD_TO_TURN = 64'd2734261102;
   localparam int HEADING_SHIFT = 10;

   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;

   localparam int TAIL_CYCLES = 150;

   typedef struct {
      logic [ddo_pkg::CMD_W-1:0] cmd;
      logic [31:0] lin_vel;
      logic [31:0] ang_vel;
      logic [31:0] right_rate;
      logic [31:0] left_rate;
      logic [31:0] load_x;
      logic [31:0] load_y;
      logic [31:0] load_heading;
   } odo_req_type;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] heading;
      logic        saturated;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ddo_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ddo_pkg::CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ddo_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ddo_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ddo_pkg::CFG_W-1:0] csr_wdata = '0;

   // atan(2^-k) in turns, 2^32 per turn
   logic [31:0] atan_steps [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // predicted pose and register copies
   logic [31:0] model_x = '0;
   logic [31:0] model_y = '0;
   logic [31:0] model_hd = '0;
   logic [23:0] cfg_radius = DEFAULT_RADIUS;
   logic [23:0] cfg_axle = DEFAULT_AXLE;
   logic [23:0] cfg_tstep = DEFAULT_TSTEP;

   pose_type pending_poses [$];
   int       fail_count = 0;
   int       burst_left = 0;
   int       stall_run = 0;
   int       stall_mode = 0;
   pose_type want;

   diff_drive_odometry dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint round_up_shift(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic longint clip_word(input longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
         hit = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         hit = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // cos and sin in Q2.30; half turns fold by flipping the sign bit
   function automatic void cordic_rotate(input logic [31:0] angle, output longint cos_q,
                                         output longint sin_q);
      longint x, y, z, nx;
      bit flip;
      int k;
      flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      if (flip) angle[31] = ~angle[31];
      x = CORDIC_GAIN;
      y = 0;
      z = longint'($signed(angle));
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         k = i % 32;
         if (z >= 0) begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z = z - longint'(atan_steps[k]);
         end else begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z = z + longint'(atan_steps[k]);
         end
         x = nx;
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
   endfunction

   // w*Ts in rad converted to turns, rounded half away from zero
   function automatic logic [31:0] heading_delta(input longint omega);
      longint prod;
      longint unsigned mag, hi, lo, acc;
      logic [31:0] d;
      prod = omega * longint'(cfg_tstep);
      mag = (prod < 0) ? -prod : prod;
      hi = (mag >> 32) * RAD_TO_TURN;
      lo = (mag & 64'h0000_0000_FFFF_FFFF) * RAD_TO_TURN;
      acc = hi + (lo >> 32) + (64'd1 << (HEADING_SHIFT - 1));
      d = 32'(acc >> HEADING_SHIFT);
      return (prod < 0) ? 32'(-d) : d;
   endfunction

   function automatic logic [31:0] step_axis(input logic [31:0] pos, input longint vel,
                                             input longint trig, inout bit hit);
      longint along, delta, moved;
      along = round_up_shift(vel * trig, 30);
      delta = round_up_shift(along * longint'(cfg_tstep), 24);
      moved = clip_word(longint'($signed(pos)) + delta, hit);
      return moved[31:0];
   endfunction

   task automatic advance_pose(input odo_req_type item);
      longint vel, omega, cos_q, sin_q, wr, wl, rad, len;
      bit clip_hit, ignored_hit;
      pose_type res;
      clip_hit = 1'b0;
      ignored_hit = 1'b0;
      case (item.cmd)
         ddo_pkg::CMD_LOAD: begin
            model_x = item.load_x;
            model_y = item.load_y;
            model_hd = item.load_heading;
         end
         ddo_pkg::CMD_BODY, ddo_pkg::CMD_WHEEL: begin
            if (item.cmd == ddo_pkg::CMD_BODY) begin
               vel = longint'($signed(item.lin_vel));
               omega = longint'($signed(item.ang_vel));
            end else begin
               wr = longint'($signed(item.right_rate));
               wl = longint'($signed(item.left_rate));
               rad = longint'(cfg_radius);
               // zero axle length acts as the smallest step
               len = (cfg_axle == 0) ? 64'sd1 : longint'(cfg_axle);
               vel = clip_word(round_up_shift(rad * (wr + wl), 17), ignored_hit);
               omega = clip_word((rad * (wr - wl)) / len, ignored_hit);
            end
            cordic_rotate(model_hd, cos_q, sin_q);
            model_x = step_axis(model_x, vel, cos_q, clip_hit);
            model_y = step_axis(model_y, vel, sin_q, clip_hit);
            model_hd = model_hd + heading_delta(omega);
         end
         default: ;
      endcase
      res.pos_x = model_x;
      res.pos_y = model_y;
      res.heading = model_hd;
      res.saturated = clip_hit;
      pending_poses.push_back(res);
   endtask

   // ---------------------------------------------------------------- request side

   task automatic send_cmd(input odo_req_type item);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= item.cmd;
      req_tdata <= {item.load_heading, item.load_y, item.load_x, item.left_rate,
                    item.right_rate, item.ang_vel, item.lin_vel};
      do @(posedge clock); while (!req_tready);
      advance_pose(item);
      // bursts of back-to-back beats, with gaps of random length between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(0, 8);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150)
                                          : $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_pending();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ddo_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [23:0] value);
      drain_pending();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ddo_pkg::CSR_WHEEL_RADIUS: cfg_radius = value;
         ddo_pkg::CSR_AXLE_LENGTH:  cfg_axle = value;
         ddo_pkg::CSR_TIME_STEP:    cfg_tstep = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic odo_req_type junk_req();
      odo_req_type r;
      r.cmd = 2'($urandom_range(0, 3));
      r.lin_vel = $urandom;
      r.ang_vel = $urandom;
      r.right_rate = $urandom;
      r.left_rate = $urandom;
      r.load_x = $urandom;
      r.load_y = $urandom;
      r.load_heading = $urandom;
      return r;
   endfunction

   function automatic odo_req_type body_cmd(input logic [31:0] lin, input logic [31:0] ang);
      odo_req_type r;
      r = junk_req();
      r.cmd = ddo_pkg::CMD_BODY;
      r.lin_vel = lin;
      r.ang_vel = ang;
      return r;
   endfunction

   function automatic odo_req_type wheel_cmd(input logic [31:0] wr, input logic [31:0] wl);
      odo_req_type r;
      r = junk_req();
      r.cmd = ddo_pkg::CMD_WHEEL;
      r.right_rate = wr;
      r.left_rate = wl;
      return r;
   endfunction

   function automatic odo_req_type load_cmd(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] hd);
      odo_req_type r;
      r = junk_req();
      r.cmd = ddo_pkg::CMD_LOAD;
      r.load_x = x;
      r.load_y = y;
      r.load_heading = hd;
      return r;
   endfunction

   function automatic odo_req_type unused_cmd();
      odo_req_type r;
      r = junk_req();
      r.cmd = CMD_UNUSED;
      return r;
   endfunction

   // mostly plausible speeds, some full-range words and range ends
   function automatic logic [31:0] pick_rate();
      logic [31:0] extremes [5];
      extremes = '{WORD_MAX, WORD_MIN, 32'd0, 32'd1, 32'hFFFF_FFFF};
      case ($urandom_range(0, 9))
         6, 7:    return $urandom;
         8:       return extremes[$urandom_range(0, 4)];
         9:       return 32'($urandom_range(0, 200)) - 32'd100;
         default: return 32'($urandom_range(0, 1310720)) - 32'd655360;
      endcase
   endfunction

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 9))
         7:       return 32'h7FFF_0000 + 32'($urandom_range(0, 16'hFFFF));
         8:       return WORD_MIN + 32'($urandom_range(0, 16'hFFFF));
         9:       return $urandom;
         default: return 32'($urandom_range(0, 13107200)) - 32'd6553600;
      endcase
   endfunction

   function automatic logic [23:0] pick_cfg(input int lo, input int hi,
                                            input logic [23:0] dflt);
      case ($urandom_range(0, 9))
         0:       return 24'd0;
         1:       return 24'd1;
         2:       return CFG_MAX;
         3:       return dflt;
         4:       return 24'($urandom);
         default: return 24'($urandom_range(lo, hi));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_load_and_hold();
      send_cmd(load_cmd(WORD_MAX, WORD_MAX, WORD_MAX));
      send_cmd(unused_cmd());
      send_cmd(load_cmd(WORD_MIN, WORD_MIN, WORD_MIN));
      send_cmd(load_cmd(32'd0, 32'd0, 32'd0));
   endtask

   // steps right at the quadrant edges where the cordic folds
   task automatic test_body_quadrants();
      logic [31:0] headings [4];
      headings = '{32'h3FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'hC000_0001};
      foreach (headings[i]) begin
         send_cmd(load_cmd(32'd0, 32'd0, headings[i]));
         if (i % 2 == 0) send_cmd(body_cmd(WORD_MAX, WORD_MIN));
         else send_cmd(body_cmd(WORD_MIN, WORD_MAX));
      end
   endtask

   task automatic test_position_clip();
      send_cmd(load_cmd(32'h7FFF_0000, 32'h8001_0000, 32'h2000_0000));
      send_cmd(body_cmd(WORD_MAX, 32'd0));
      send_cmd(load_cmd(32'd0, 32'h8001_0000, 32'hA000_0000));
      send_cmd(body_cmd(WORD_MAX, 32'd0));
   endtask

   task automatic test_wheel_rates();
      send_cmd(wheel_cmd(WORD_MAX, WORD_MAX));
      send_cmd(wheel_cmd(WORD_MAX, WORD_MIN));
      send_cmd(wheel_cmd(WORD_MIN, WORD_MAX));
      // largest radius pushes the derived v and w past the word range
      write_reg(ddo_pkg::CSR_WHEEL_RADIUS, CFG_MAX);
      send_cmd(wheel_cmd(WORD_MAX, WORD_MIN));
      send_cmd(wheel_cmd(WORD_MIN, WORD_MIN));
   endtask

   task automatic test_register_extremes();
      write_reg(ddo_pkg::CSR_AXLE_LENGTH, 24'd0);
      send_cmd(wheel_cmd(32'h0005_0000, 32'hFFFB_0000));
      write_reg(ddo_pkg::CSR_WHEEL_RADIUS, 24'd0);
      send_cmd(wheel_cmd(pick_rate(), pick_rate()));
      write_reg(ddo_pkg::CSR_WHEEL_RADIUS, 24'd1);
      write_reg(ddo_pkg::CSR_TIME_STEP, 24'd0);
      send_cmd(body_cmd(WORD_MAX, WORD_MAX));
      write_reg(ddo_pkg::CSR_TIME_STEP, CFG_MAX);
      write_reg(ddo_pkg::CSR_AXLE_LENGTH, CFG_MAX);
      write_reg(CSR_SPARE, 24'($urandom));
      send_cmd(wheel_cmd(32'h0020_0000, 32'hFFF0_0000));
      write_reg(ddo_pkg::CSR_WHEEL_RADIUS, DEFAULT_RADIUS);
      write_reg(ddo_pkg::CSR_AXLE_LENGTH, DEFAULT_AXLE);
      write_reg(ddo_pkg::CSR_TIME_STEP, DEFAULT_TSTEP);
   endtask

   task automatic test_random_traffic();
      int pick;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase != 0) begin
            write_reg(ddo_pkg::CSR_WHEEL_RADIUS, pick_cfg(1000, 20000, DEFAULT_RADIUS));
            write_reg(ddo_pkg::CSR_AXLE_LENGTH, pick_cfg(10000, 100000, DEFAULT_AXLE));
            write_reg(ddo_pkg::CSR_TIME_STEP, pick_cfg(1000, 2000000, DEFAULT_TSTEP));
         end
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) send_cmd(load_cmd(pick_pos(), pick_pos(), $urandom));
            else if (pick < 10) send_cmd(unused_cmd());
            else if (pick < 55) send_cmd(body_cmd(pick_rate(), pick_rate()));
            else send_cmd(wheel_cmd(pick_rate(), pick_rate()));
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   // receiver alternates between free flow, random stalls, sparse ready and hard stalls
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_run <= $urandom_range(5, 60);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (stall_run > 40);
      endcase
   end

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected %h, actual %h", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_poses.size() == 0) begin
            $error("rsp beat with no pending pose: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_poses.pop_front();
            check_field("pos_x", want.pos_x, rsp_tdata[31:0]);
            check_field("pos_y", want.pos_y, rsp_tdata[63:32]);
            check_field("heading", want.heading, rsp_tdata[95:64]);
            check_field("saturated", 32'(want.saturated), 32'(rsp_tuser));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_load_and_hold();
      test_body_quadrants();
      test_position_clip();
      test_wheel_rates();
      test_register_extremes();
      test_random_traffic();
      drain_pending();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
